// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the range count block.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RCNAB_ASSERT_CLK(lbl, clock, resetn, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Concurrent assertion on the usual clk and rst_n of the including module.
`define RCNAB_ASSERT(lbl, prop, msg) \
  `RCNAB_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ----- hdl/rcnab_pkg.sv -----
// Package of the range count block: transaction structs, codes and the scan token.
// No dependencies; used by every module of the block.
`default_nettype none

package rcnab_pkg;

  localparam int unsigned MATCH_W = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          range_low;
    logic [POS_W-1:0]          range_high;
    logic signed [VALUE_W-1:0] value_bound;
  } in_item_t;

  typedef struct packed {
    logic [MATCH_W-1:0] match_count;
    logic [1:0]         status;
  } out_item_t;

  // Query parameters broadcast to every cell while a scan runs.
  typedef struct packed {
    logic [POS_W-1:0]          range_low;
    logic [POS_W-1:0]          range_high;
    logic signed [VALUE_W-1:0] value_bound;
  } query_t;

  // Running count that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic [MATCH_W-1:0] count;
  } scan_tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/rcnab_cell.sv -----
// One storage cell of the range count row: holds one value and updates the scan token.
// Depends on rcnab_pkg.
`default_nettype none

module rcnab_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [IDX_W-1:0]                wr_idx,
  input  wire logic signed [rcnab_pkg::VALUE_W-1:0] wr_value,
  input  wire rcnab_pkg::query_t               qry,
  input  wire rcnab_pkg::scan_tok_t            tok_in,
  output rcnab_pkg::scan_tok_t                 tok_out
);

  localparam int unsigned RW = (IDX_W > rcnab_pkg::POS_W) ? IDX_W : rcnab_pkg::POS_W;

  logic signed [rcnab_pkg::VALUE_W-1:0] value_r;
  rcnab_pkg::scan_tok_t                 tok_r;
  rcnab_pkg::scan_tok_t                 tok_nxt;
  logic                                 in_range;
  logic                                 hit;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(IDX))) begin
      value_r <= wr_value;
    end
  end

  assign in_range = (RW'(qry.range_low) <= RW'(IDX)) && (RW'(IDX) <= RW'(qry.range_high));
  assign hit      = in_range && (value_r <= qry.value_bound);

  always_comb begin
    tok_nxt.vld   = tok_in.vld;
    tok_nxt.count = tok_in.count + rcnab_pkg::MATCH_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.count <= tok_nxt.count;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ----- hdl/rcnab_chain.sv -----
// The row of storage cells; the scan token enters at cell 0 and leaves after the last.
// Depends on rcnab_pkg and rcnab_cell.
`default_nettype none

module rcnab_chain #(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned IDX_W     = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 wr_en,
  input  wire logic [IDX_W-1:0]                     wr_idx,
  input  wire logic signed [rcnab_pkg::VALUE_W-1:0] wr_value,
  input  wire rcnab_pkg::query_t                    qry,
  input  wire rcnab_pkg::scan_tok_t                 tok_head,
  output rcnab_pkg::scan_tok_t                      tok_tail
);

  rcnab_pkg::scan_tok_t tok [MAX_ITEMS+1];

  assign tok[0] = tok_head;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rcnab_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_value (wr_value),
      .qry      (qry),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign tok_tail = tok[MAX_ITEMS];

endmodule

`default_nettype wire

// ----- hdl/range_count_not_above_bound.sv -----
// Top level of the range count block: handshake, item count, control and result register.
// Depends on rcnab_pkg, rcnab_chain (and through it rcnab_cell) and assert_macros.svh.
//
// The block keeps a list of signed 32-bit values in a row of MAX_ITEMS cells, one value
// per cell. An append transaction writes its value into the cell at the current item
// count; its result is registered at the edge that accepts it, as is the zero result of a
// clear, which resets the count, and of the unused command code. A query transaction
// counts the positions from range_low to range_high, both included, whose value is at
// most value_bound under signed comparison. It launches a running count into cell 0;
// the count moves one cell per clock, each cell adding one when its position lies in
// the range and its value passes the bound; from the last cell it goes through the scan
// result register to the output register, so the length of the row sets the wait.
// Every transaction gives exactly one result. Status reports a full store on an append
// beyond MAX_ITEMS, and a bad range when range_low is above range_high or range_high is
// not below the count; such results carry a zero count. Only positions up to 1023 can be
// named by a query. The stored values need no clearing: only written cells are ever
// counted. Input transactions are taken one at a time: the input stalls while a scan
// runs and while a finished result is held in the output register by a stall, so the
// next transaction is accepted at the earliest at the edge where the previous result
// leaves.
`default_nettype none
`include "assert_macros.svh"

module range_count_not_above_bound #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire rcnab_pkg::in_item_t  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      rcnab_pkg::out_item_t out_data
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CMP_W = (CNT_W > rcnab_pkg::POS_W) ? CNT_W : rcnab_pkg::POS_W;

  rcnab_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]     item_cnt_r, item_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rcnab_pkg::out_item_t out_data_r, out_data_nxt;
  rcnab_pkg::query_t    qry_r, qry_nxt;
  logic                 start_r, start_nxt;
  logic [rcnab_pkg::MATCH_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 is_full;
  logic                 range_ok;
  logic                 query_go;
  logic                 wr_en;
  rcnab_pkg::scan_tok_t tok_head;
  rcnab_pkg::scan_tok_t tok_tail;

  // The output register is free when empty or when its result leaves at this edge.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != rcnab_pkg::S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign is_full  = (item_cnt_r == CNT_W'(MAX_ITEMS));
  assign range_ok = (in_data.range_low <= in_data.range_high) &&
                    (CMP_W'(in_data.range_high) < CMP_W'(item_cnt_r));
  assign query_go = in_acc && (in_data.command == rcnab_pkg::CMD_QUERY) && range_ok;
  assign wr_en    = in_acc && (in_data.command == rcnab_pkg::CMD_APPEND) && !is_full;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcnab_pkg::S_IDLE: begin
        if (query_go) begin
          state_nxt = rcnab_pkg::S_SCAN;
        end
      end
      rcnab_pkg::S_SCAN: begin
        if (tok_tail.vld) begin
          state_nxt = rcnab_pkg::S_HOLD;
        end
      end
      rcnab_pkg::S_HOLD: begin
        if (out_free) begin
          state_nxt = rcnab_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rcnab_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and result control.
  always_comb begin
    item_cnt_nxt  = item_cnt_r;
    qry_nxt       = qry_r;
    start_nxt     = 1'b0;
    res_cnt_nxt   = res_cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      rcnab_pkg::S_IDLE: begin
        if (in_acc) begin
          out_data_nxt.match_count = '0;
          out_data_nxt.status      = rcnab_pkg::ST_OK;
          unique case (in_data.command)
            rcnab_pkg::CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_data_nxt.status = rcnab_pkg::ST_FULL;
              end else begin
                item_cnt_nxt = item_cnt_r + CNT_W'(1);
              end
            end
            rcnab_pkg::CMD_QUERY: begin
              if (range_ok) begin
                // Result follows once the count has passed the whole row.
                qry_nxt.range_low   = in_data.range_low;
                qry_nxt.range_high  = in_data.range_high;
                qry_nxt.value_bound = in_data.value_bound;
                start_nxt           = 1'b1;
              end else begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = rcnab_pkg::ST_BAD_RANGE;
              end
            end
            rcnab_pkg::CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              item_cnt_nxt  = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      rcnab_pkg::S_SCAN: begin
        if (tok_tail.vld) begin
          res_cnt_nxt = tok_tail.count;
        end
      end
      rcnab_pkg::S_HOLD: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.match_count = res_cnt_r;
          out_data_nxt.status      = rcnab_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcnab_pkg::S_IDLE;
      item_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_cnt_r  <= item_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
    end
    out_data_r <= out_data_nxt;
    qry_r      <= qry_nxt;
    res_cnt_r  <= res_cnt_nxt;
  end

  always_comb begin
    tok_head.vld   = start_r;
    tok_head.count = '0;
  end

  rcnab_chain #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_idx   (item_cnt_r[IDX_W-1:0]),
    .wr_value (in_data.value),
    .qry      (qry_r),
    .tok_head (tok_head),
    .tok_tail (tok_tail)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The item count never runs past the number of cells.
  `RCNAB_ASSERT(a_cnt_bounded, item_cnt_r <= CNT_W'(MAX_ITEMS), "item count above capacity")
  // A count only reaches the end of the row while a scan is in progress.
  `RCNAB_ASSERT(a_tail_in_scan, tok_tail.vld |-> (state_r == rcnab_pkg::S_SCAN), "stray scan token")
  // A valid query must launch a scan and raise the start flag.
  `RCNAB_ASSERT(a_query_scans, query_go |=> (state_r == rcnab_pkg::S_SCAN) && start_r, "query did not start a scan")
  // The item count is touched only by an accepted transaction.
  `RCNAB_ASSERT(a_cnt_steady, !in_acc |=> $stable(item_cnt_r), "item count changed without a transaction")

endmodule

`default_nettype wire
